>>> src/bdq_pkg.sv
// Package for the bounded deque: command and status codes, field widths and
// the memory operation record passed from the control unit to the top level.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int CmdW = 3;
	localparam int ValW = 32;
	localparam int IdxW = 8;
	localparam int StW  = 2;

	typedef enum logic [CmdW-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	typedef enum logic [StW-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY_POP = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_FULL_PUSH = 2'd3
	} status_t;

	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		status_t status;
	} mem_op_t;

endpackage

>>> src/bdq_ctrl.sv
// Deque control: front pointer and count registers, command decode and the
// ring address of the entry that a command touches.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_ctrl import bdq_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int PtrW = $clog2(DEPTH),
	localparam int CntW = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  cmd_t                   command,
	input  logic [IdxW-1:0]        index,
	output mem_op_t                op,
	output logic [PtrW-1:0]        addr,
	output logic [CntW-1:0]        count_nxt
);

	localparam int CmpW = (CntW > IdxW) ? CntW : IdxW;

	logic [PtrW-1:0] front_q;
	logic [CntW-1:0] count_q;
	logic [PtrW-1:0] front_nxt;
	logic            full;
	logic            empty;
	logic            idx_ok;
	logic [PtrW-1:0] front_dec;
	logic [PtrW-1:0] front_inc;

	function automatic logic [PtrW-1:0] wrap_add(logic [PtrW-1:0] base, logic [PtrW-1:0] ofs);
		logic [PtrW:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= (PtrW+1)'(DEPTH)) begin
			sum = sum - (PtrW+1)'(DEPTH);
		end
		return sum[PtrW-1:0];
	endfunction

	assign full      = (count_q == CntW'(DEPTH));
	assign empty     = (count_q == '0);
	assign idx_ok    = (CmpW'(index) < CmpW'(count_q));
	assign front_dec = (front_q == '0) ? PtrW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PtrW'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	always_comb begin
		op        = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_OK};
		addr      = front_q;
		front_nxt = front_q;
		count_nxt = count_q;
		unique case (command)
			CMD_PUSH_FRONT: begin
				if (full) begin
					op.status = ST_FULL_PUSH;
				end else begin
					op.wr_en  = 1'b1;
					addr      = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					op.status = ST_FULL_PUSH;
				end else begin
					op.wr_en  = 1'b1;
					addr      = wrap_add(front_q, count_q[PtrW-1:0]);
					count_nxt = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					op.status = ST_EMPTY_POP;
				end else begin
					front_nxt = front_inc;
					count_nxt = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					op.status = ST_EMPTY_POP;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (!idx_ok) begin
					op.status = ST_BAD_INDEX;
				end else begin
					op.rd_en = 1'b1;
					addr     = wrap_add(front_q, PtrW'(index));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

>>> src/bounded_deque_with_indexed_read.sv
// Bounded deque of signed 32-bit words with indexed read: top level with the
// entry memory and the result register.
// Depends on bdq_pkg and bdq_ctrl.
//
// Usage: one command per transaction on the s_ channel (push front, push back,
// pop front, pop back, read at a position from the front). Each command gives
// exactly one result transaction on the m_ channel carrying the read word, a
// status code, the empty flag and the count after the command.
// The result is registered and valid in the cycle after the command is accepted;
// the entry memory is synchronous and its registered read port delivers the word.
// Throughput: one command per cycle while the receiver takes every result;
// s_tready stays high as long as the result register is empty or being taken.
// A stalled receiver holds the result and stalls the input after one command.
// Reset clears the front pointer, the count and the result register, so the
// deque starts empty; the memory is not cleared, since no position below the
// count is ever unwritten.
// Failed pushes, pops and reads report their status and leave the deque as is.
`timescale 1ns / 1ps

module bounded_deque_with_indexed_read import bdq_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int CntW = $clog2(DEPTH + 1),
	localparam int InW  = ((CmdW + ValW + IdxW + 7) / 8) * 8,
	localparam int OutW = ((ValW + StW + 1 + CntW + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [InW-1:0]  s_tdata,  // command, value, index
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OutW-1:0] m_tdata   // read_data, status, is_empty, item_count
);

	localparam int PtrW = $clog2(DEPTH);

	logic                   accept;
	cmd_t                   command;
	logic signed [ValW-1:0] value;
	logic [IdxW-1:0]        index;
	mem_op_t                op;
	logic [PtrW-1:0]        addr;
	logic [CntW-1:0]        count_nxt;

	logic signed [ValW-1:0] mem [DEPTH];
	logic signed [ValW-1:0] rdata_s1;
	logic                   valid_s1;
	logic                   rd_s1;
	status_t                status_s1;
	logic [CntW-1:0]        count_s1;
	logic signed [ValW-1:0] read_data;
	logic                   is_empty;

	assign command = cmd_t'(s_tdata[CmdW-1:0]);
	assign value   = s_tdata[CmdW+ValW-1:CmdW];
	assign index   = s_tdata[CmdW+ValW+IdxW-1:CmdW+ValW];

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	bdq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.index    (index),
		.op       (op),
		.addr     (addr),
		.count_nxt(count_nxt)
	);

	always_ff @(posedge clk) begin
		if (accept && op.wr_en) begin
			mem[addr] <= value;
		end
		if (accept && op.rd_en) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rd_s1     <= 1'b0;
			status_s1 <= ST_OK;
			count_s1  <= '0;
		end else if (accept) begin
			valid_s1  <= 1'b1;
			rd_s1     <= op.rd_en;
			status_s1 <= op.status;
			count_s1  <= count_nxt;
		end else if (m_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign read_data = rd_s1 ? rdata_s1 : '0;
	assign is_empty  = (count_s1 == '0);
	assign m_tvalid  = valid_s1;
	assign m_tdata   = OutW'({count_s1, is_empty, status_s1, read_data});

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rd_s1 |-> status_s1 == ST_OK && count_s1 != '0)
		else $error("read result without ok status or with empty deque");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_s1 <= CntW'(DEPTH))
		else $error("count exceeds depth");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted command gave no result");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && status_s1 == ST_FULL_PUSH |-> count_s1 == CntW'(DEPTH))
		else $error("full push flagged while not full");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && status_s1 == ST_EMPTY_POP |-> count_s1 == '0)
		else $error("empty pop flagged while not empty");

endmodule
